// File: rtl/tbgd_pkg.sv
// Shared types and constants for the two-button gesture decoder.
package tbgd_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_DEBOUNCE_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_DOUBLE_WINDOW    = 3'd1;
   localparam logic [2:0] CSR_CHORD_WINDOW     = 3'd2;
   localparam logic [2:0] CSR_CLEAR_HOLD_TICKS = 3'd3;
   localparam logic [2:0] CSR_REPEAT_TICKS     = 3'd4;

   // Configuration reset values.
   localparam logic [6:0]  RST_DEBOUNCE_LIMIT   = 7'd101;
   localparam logic [15:0] RST_DOUBLE_WINDOW    = 16'd250;
   localparam logic [15:0] RST_CHORD_WINDOW     = 16'd100;
   localparam logic [15:0] RST_CLEAR_HOLD_TICKS = 16'd2000;
   localparam logic [15:0] RST_REPEAT_TICKS     = 16'd1000;

   // Button press phases (two's complement of the signed phase values).
   localparam logic [2:0] PH_CHORD   = 3'b101;
   localparam logic [2:0] PH_IDLE    = 3'b110;
   localparam logic [2:0] PH_RELEASE = 3'b111;
   localparam logic [2:0] PH_CONFIRM = 3'b000;
   localparam logic [2:0] PH_PRESS   = 3'b001;

   // Gesture event codes.
   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_CHORD      = 3'd1;
   localparam logic [2:0] EV_CLEAR      = 3'd2;
   localparam logic [2:0] EV_DOUBLE     = 3'd3;
   localparam logic [2:0] EV_SINGLE     = 3'd4;
   localparam logic [2:0] EV_SW1_PRESS  = 3'd5;
   localparam logic [2:0] EV_SW1_REPEAT = 3'd6;

   // LED masks (active low, one bit per LED).
   localparam logic [3:0] LED_ALL_OFF  = 4'hF;
   localparam logic [3:0] LED_CHORD    = 4'hB;
   localparam logic [3:0] LED_DOUBLE   = 4'h5;
   localparam logic [3:0] LED_SINGLE   = 4'h1;
   localparam logic [3:0] LED_SW1      = 4'h2;

   typedef struct packed {
      logic [6:0]  debounce_limit;
      logic [15:0] double_window;
      logic [15:0] chord_window;
      logic [15:0] clear_hold_ticks;
      logic [15:0] repeat_ticks;
   } tbgd_cfg_type;

   typedef struct packed {
      logic sw0_level;
      logic sw1_level;
      logic tick;
   } tbgd_req_type;

   typedef struct packed {
      logic [3:0] leds;
      logic [2:0] event_res;
   } tbgd_rsp_type;

   // Narrow gesture state; the time fields travel separately.
   typedef struct packed {
      logic [6:0]  debounce0;
      logic [6:0]  debounce1;
      logic [2:0]  phase0;
      logic [2:0]  phase1;
      logic [15:0] press_count;
      logic [3:0]  led_state;
   } tbgd_ctl_type;

endpackage

// File: rtl/tbgd_csr.sv
// Configuration registers of the gesture decoder.
module tbgd_csr
   import tbgd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   output tbgd_cfg_type cfg
);

   tbgd_cfg_type cfg_ff;
   tbgd_cfg_type cfg_in;

   // Writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE_LIMIT:   cfg_in.debounce_limit   = csr_wdata[6:0];
            CSR_DOUBLE_WINDOW:    cfg_in.double_window    = csr_wdata;
            CSR_CHORD_WINDOW:     cfg_in.chord_window     = csr_wdata;
            CSR_CLEAR_HOLD_TICKS: cfg_in.clear_hold_ticks = csr_wdata;
            CSR_REPEAT_TICKS:     cfg_in.repeat_ticks     = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit   <= RST_DEBOUNCE_LIMIT;
         cfg_ff.double_window    <= RST_DOUBLE_WINDOW;
         cfg_ff.chord_window     <= RST_CHORD_WINDOW;
         cfg_ff.clear_hold_ticks <= RST_CLEAR_HOLD_TICKS;
         cfg_ff.repeat_ticks     <= RST_REPEAT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/tbgd_step.sv
// Gesture rules for one poll: next state and result from current state.
module tbgd_step
   import tbgd_pkg::*;
#(
   parameter int TIME_BITS = 16
)(
   input  tbgd_cfg_type         cfg,
   input  tbgd_req_type         req,
   input  tbgd_ctl_type         ctl_cur,
   input  logic [TIME_BITS-1:0] tick_count_cur,
   input  logic [TIME_BITS-1:0] capture0_cur,
   input  logic [TIME_BITS-1:0] capture1_cur,
   output tbgd_ctl_type         ctl_nxt,
   output logic [TIME_BITS-1:0] tick_count_nxt,
   output logic [TIME_BITS-1:0] capture0_nxt,
   output logic [TIME_BITS-1:0] capture1_nxt,
   output tbgd_rsp_type         rsp
);

   localparam int CmpW = (TIME_BITS > 16) ? TIME_BITS : 16;

   localparam logic [TIME_BITS-1:0] TimeOne = {{(TIME_BITS-1){1'b0}}, 1'b1};

   // Wrapped time difference, widened for comparison with a 16-bit window.
   function automatic logic [CmpW-1:0] since_f(input logic [TIME_BITS-1:0] a,
                                               input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] d;
      d = a - b;
      return CmpW'(d);
   endfunction

   logic                 press0;
   logic                 press1;
   logic [TIME_BITS-1:0] now;
   logic [CmpW-1:0]      dwin;
   logic [CmpW-1:0]      cwin;
   logic [CmpW-1:0]      hold;
   logic [CmpW-1:0]      rpt;
   logic                 chord_hit;
   logic                 clear_hit;
   logic                 sw0_hit;
   logic                 sw1_hit;
   logic [2:0]           ev;

   assign press0 = ~req.sw0_level;
   assign press1 = ~req.sw1_level;
   assign now    = tick_count_cur + TIME_BITS'(req.tick);
   assign dwin   = CmpW'(cfg.double_window);
   assign cwin   = CmpW'(cfg.chord_window);
   assign hold   = CmpW'(cfg.clear_hold_ticks);
   assign rpt    = CmpW'(cfg.repeat_ticks);

   // Chord looks only at the state before this poll; clear also counts this poll's tick.
   assign chord_hit = (ctl_cur.phase0 == PH_CONFIRM) && (ctl_cur.phase1 == PH_CONFIRM) &&
                      ((since_f(capture0_cur, capture1_cur) <= cwin) ||
                       (since_f(capture1_cur, capture0_cur) <= cwin));
   assign clear_hit = (ctl_cur.phase0 == PH_CONFIRM) &&
                      (since_f(now, capture0_cur) >= hold);

   // Rules in fixed priority; button steps keep their side effects when they do not fire.
   always_comb begin
      ctl_nxt        = ctl_cur;
      tick_count_nxt = now;
      capture0_nxt   = capture0_cur;
      capture1_nxt   = capture1_cur;
      ev             = EV_NONE;
      sw0_hit        = 1'b0;
      sw1_hit        = 1'b0;
      if (chord_hit) begin
         ctl_nxt.phase0    = PH_CHORD;
         ctl_nxt.phase1    = PH_CHORD;
         ctl_nxt.led_state = ctl_cur.led_state ^ LED_CHORD;
         ev                = EV_CHORD;
      end else if (clear_hit) begin
         ctl_nxt.led_state = LED_ALL_OFF;
         tick_count_nxt    = TimeOne;
         capture0_nxt      = TimeOne;
         ev                = EV_CLEAR;
      end else begin
         // Button 0 debounce and press confirmation.
         if (press0 && (ctl_cur.debounce0 < cfg.debounce_limit)) begin
            capture0_nxt      = now;
            ctl_nxt.debounce0 = ctl_cur.debounce0 + 7'd1;
            ctl_nxt.phase0    = PH_PRESS;
         end else if (!press0 && (ctl_cur.debounce0 != 7'd0)) begin
            ctl_nxt.debounce0 = ctl_cur.debounce0 - 7'd1;
            ctl_nxt.phase0    = PH_RELEASE;
         end else if (!press0 && (since_f(now, capture0_cur) > dwin) &&
                      (ctl_cur.press_count == 16'd1)) begin
            ctl_nxt.press_count = 16'd0;
         end else if ((ctl_cur.debounce0 == cfg.debounce_limit) &&
                      (ctl_cur.phase0 == PH_PRESS)) begin
            ctl_nxt.phase0 = PH_CONFIRM;
            if (since_f(now, capture0_cur) > dwin) begin
               capture0_nxt        = now;
               ctl_nxt.press_count = 16'd0;
            end else begin
               ctl_nxt.press_count = ctl_cur.press_count + 16'd1;
            end
            sw0_hit = 1'b1;
         end

         if (sw0_hit) begin
            // Double press versus single press.
            if ((ctl_nxt.press_count >= 16'd2) && (since_f(now, capture0_nxt) < dwin)) begin
               ctl_nxt.press_count = 16'd0;
               ctl_nxt.led_state   = ctl_cur.led_state ^ LED_DOUBLE;
               ev                  = EV_DOUBLE;
            end else begin
               ctl_nxt.led_state = ctl_cur.led_state ^ LED_SINGLE;
               ev                = EV_SINGLE;
            end
         end else begin
            // Button 1 debounce, then its confirmation check on the new values.
            if (press1 && (ctl_cur.debounce1 < cfg.debounce_limit)) begin
               ctl_nxt.debounce1 = ctl_cur.debounce1 + 7'd1;
               ctl_nxt.phase1    = PH_PRESS;
            end else if (!press1 && (ctl_cur.debounce1 != 7'd0)) begin
               ctl_nxt.debounce1 = ctl_cur.debounce1 - 7'd1;
               ctl_nxt.phase1    = PH_RELEASE;
            end
            if ((ctl_nxt.debounce1 == cfg.debounce_limit) && (ctl_nxt.phase1 == PH_PRESS)) begin
               ctl_nxt.phase1 = PH_CONFIRM;
               capture1_nxt   = now;
               sw1_hit        = 1'b1;
            end

            if (sw1_hit) begin
               ctl_nxt.led_state = ctl_cur.led_state ^ LED_SW1;
               ev                = EV_SW1_PRESS;
            end else if ((since_f(now, capture1_cur) >= rpt) &&
                         (ctl_nxt.phase1 == PH_CONFIRM)) begin
               ctl_nxt.led_state = ctl_cur.led_state ^ LED_SW1;
               tick_count_nxt    = TimeOne;
               capture1_nxt      = TimeOne;
               ev                = EV_SW1_REPEAT;
            end
         end
      end
   end

   assign rsp.leds      = ctl_nxt.led_state;
   assign rsp.event_res = ev;

endmodule

// File: rtl/two_button_gesture_decoder.sv
// Two-button gesture decoder: input register, gesture rules and result register.
// A poll is held in the input register, passes the gesture rules and lands in the result register.
// Throughput: one poll per cycle unless rsp_stall holds a full result register; the rules sit between the registers.
// A result held by rsp_stall stalls the input only when the input register is also full.
// Reset (synchronous, active high) restores the configuration defaults, clears the
// counters and captures, sets both buttons idle and turns all LEDs off.
module two_button_gesture_decoder
   import tbgd_pkg::*;
#(
   parameter int TIME_BITS = 16
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  tbgd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output tbgd_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   tbgd_cfg_type         cfg;

   logic                 req_valid_ff;
   logic                 req_valid_in;
   tbgd_req_type         req_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   tbgd_rsp_type         rsp_ff;
   tbgd_rsp_type         rsp_in;

   tbgd_ctl_type         ctl_ff;
   tbgd_ctl_type         ctl_in;
   logic [TIME_BITS-1:0] tick_count_ff;
   logic [TIME_BITS-1:0] tick_count_in;
   logic [TIME_BITS-1:0] capture0_ff;
   logic [TIME_BITS-1:0] capture0_in;
   logic [TIME_BITS-1:0] capture1_ff;
   logic [TIME_BITS-1:0] capture1_in;

   logic                 advance;
   logic                 req_take;

   tbgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tbgd_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg            (cfg),
      .req            (req_ff),
      .ctl_cur        (ctl_ff),
      .tick_count_cur (tick_count_ff),
      .capture0_cur   (capture0_ff),
      .capture1_cur   (capture1_ff),
      .ctl_nxt        (ctl_in),
      .tick_count_nxt (tick_count_in),
      .capture0_nxt   (capture0_in),
      .capture1_nxt   (capture1_in),
      .rsp            (rsp_in)
   );

   // The held poll moves into the result register when that register is free or drains.
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take     = req_valid && !req_stall;
   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Handshake control.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input and result payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Gesture state advances once for each transaction that reaches the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.debounce0   <= 7'd0;
         ctl_ff.debounce1   <= 7'd0;
         ctl_ff.phase0      <= PH_IDLE;
         ctl_ff.phase1      <= PH_IDLE;
         ctl_ff.press_count <= 16'd0;
         ctl_ff.led_state   <= LED_ALL_OFF;
         tick_count_ff      <= '0;
         capture0_ff        <= '0;
         capture1_ff        <= '0;
      end else if (advance) begin
         ctl_ff        <= ctl_in;
         tick_count_ff <= tick_count_in;
         capture0_ff   <= capture0_in;
         capture1_ff   <= capture1_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
